@@ rtl/core/mjr_pkg.sv @@
package mjr_pkg;

  localparam int CNT_W   = 17;
  localparam int TALLY_W = 5;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_STALL = 2'd2,
    MODE_ERROR = 2'd3
  } mode_t;

  localparam logic [IDX_W-1:0] REG_MIN_RUN    = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_RUN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_STALL_WAIT = 3'd2;
  localparam logic [IDX_W-1:0] REG_RETRY_RUN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_STALL_LIM  = 3'd4;
  localparam logic [IDX_W-1:0] REG_BLINK_HALF = 3'd5;

  typedef struct packed {
    logic [15:0] min_run_ticks;
    logic [15:0] max_run_ticks;
    logic [15:0] stall_wait_ticks;
    logic [15:0] retry_run_ticks;
    logic [4:0]  stall_limit;
    logic [14:0] blink_half_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic [CNT_W-1:0]   run_count;
    logic [CNT_W-1:0]   pause_count;
    logic [CNT_W-1:0]   blink_count;
    logic [TALLY_W-1:0] stall_tally;
    logic               fault_led;
  } ctl_state_t;

  function automatic logic [CNT_W-1:0] cnt_sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 17'd1;
  endfunction

endpackage

@@ rtl/core/mjr_step.sv @@
module mjr_step
  import mjr_pkg::*;
(
  input  ctl_state_t st,
  input  cfg_t       cfg,
  input  logic       button_pressed,
  input  logic       index_sensor,
  output ctl_state_t st_nxt,
  output logic       motor_on
);

  mode_t              m1;
  mode_t              m2;
  logic               ran_run;
  logic               run_end;
  logic               run_stall;
  logic [CNT_W-1:0]   run_cnt;
  logic [TALLY_W-1:0] tally1;
  logic [TALLY_W:0]   tally_inc;
  logic [CNT_W-1:0]   retry_start;
  logic [CNT_W-1:0]   blink_top;

  always_comb begin
    st_nxt = st;

    // idle block
    tally1 = st.stall_tally;
    m1     = st.mode;
    if (st.mode == MODE_IDLE) begin
      tally1 = '0;
      if (button_pressed) m1 = MODE_RUN;
    end
    st_nxt.stall_tally = tally1;

    // run block; the count restarts from zero and still advances in the tick that ends the run
    ran_run   = (m1 == MODE_RUN);
    m2        = m1;
    run_end   = ran_run && !index_sensor && (st.run_count > {1'b0, cfg.min_run_ticks});
    run_cnt   = run_end ? '0 : st.run_count;
    run_stall = ran_run && (run_cnt > {1'b0, cfg.max_run_ticks});
    tally_inc = {1'b0, tally1} + 6'd1;
    if (ran_run) begin
      if (run_end) m2 = MODE_IDLE;
      if (run_stall) begin
        m2 = (tally_inc > {1'b0, cfg.stall_limit}) ? MODE_ERROR : MODE_STALL;
        st_nxt.stall_tally = tally_inc[TALLY_W] ? TALLY_MAX : tally_inc[TALLY_W-1:0];
      end
      st_nxt.run_count = cnt_sat_inc(run_cnt);
    end
    st_nxt.mode = m2;

    // stall block
    retry_start = (cfg.retry_run_ticks > cfg.max_run_ticks) ? '0 :
                  {1'b0, cfg.max_run_ticks - cfg.retry_run_ticks};
    if (m2 == MODE_STALL) begin
      if (st.pause_count > {1'b0, cfg.stall_wait_ticks}) begin
        st_nxt.mode        = MODE_RUN;
        st_nxt.run_count   = retry_start;
        st_nxt.pause_count = cnt_sat_inc('0);
      end else begin
        st_nxt.pause_count = cnt_sat_inc(st.pause_count);
      end
    end

    // error block, led toggles around the half and full blink period
    blink_top = {1'b0, cfg.blink_half_ticks, 1'b0};
    if (m2 == MODE_ERROR) begin
      st_nxt.fault_led   = (st.blink_count > {2'b00, cfg.blink_half_ticks});
      st_nxt.blink_count = (st.blink_count > blink_top) ? cnt_sat_inc('0) :
                           cnt_sat_inc(st.blink_count);
    end

    motor_on = ran_run && (m2 == MODE_RUN || m2 == MODE_IDLE);
  end

endmodule

@@ rtl/core/motor_jam_retry_controller_top.sv @@
// Motor jam retry controller. Each input transfer is one timer tick carrying the
// button and index sensor levels; each produces exactly one result transfer with
// the motor drive, fault LED and mode after that tick. The whole tick is evaluated
// combinationally between the input handshake and the output register, so its
// result appears in the cycle after the input transfer; a new tick is taken every
// cycle while the output is not stalled. Configuration registers are written through
// cfg_we/cfg_index/cfg_wdata and come out of reset at their default timing values.
module motor_jam_retry_controller_top
  import mjr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_button_pressed,
  input  logic             in_index_sensor,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_motor_on,
  output logic             out_fault_led,
  output logic [1:0]       out_mode
);

  cfg_t       cfg_r;
  ctl_state_t st_r;
  ctl_state_t st_nxt;
  logic       motor_nxt;
  logic       out_valid_r;
  logic       motor_r;
  logic       in_xfer;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  mjr_step u_step (
    .st             (st_r),
    .cfg            (cfg_r),
    .button_pressed (in_button_pressed),
    .index_sensor   (in_index_sensor),
    .st_nxt         (st_nxt),
    .motor_on       (motor_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_run_ticks    <= 16'd500;
      cfg_r.max_run_ticks    <= 16'd3000;
      cfg_r.stall_wait_ticks <= 16'd1000;
      cfg_r.retry_run_ticks  <= 16'd300;
      cfg_r.stall_limit      <= 5'd10;
      cfg_r.blink_half_ticks <= 15'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_RUN:    cfg_r.min_run_ticks    <= cfg_wdata;
        REG_MAX_RUN:    cfg_r.max_run_ticks    <= cfg_wdata;
        REG_STALL_WAIT: cfg_r.stall_wait_ticks <= cfg_wdata;
        REG_RETRY_RUN:  cfg_r.retry_run_ticks  <= cfg_wdata;
        REG_STALL_LIM:  cfg_r.stall_limit      <= cfg_wdata[4:0];
        REG_BLINK_HALF: cfg_r.blink_half_ticks <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{mode: MODE_IDLE, default: '0};
      out_valid_r <= 1'b0;
      motor_r     <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_r    <= st_nxt;
        motor_r <= motor_nxt;
      end
      if (in_xfer) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // state register doubles as the result register for led and mode
  assign out_valid     = out_valid_r;
  assign out_motor_on  = motor_r;
  assign out_fault_led = st_r.fault_led;
  assign out_mode      = st_r.mode;

endmodule
